/* rtl/itp_pkg.sv */
// ----------------------------------------------------------------------------
// itp_pkg: shared constants and types of the isometric tile picker
// Grid geometry, accumulator width, table reset values, the sequencer
// states and the tile store request word.
// ----------------------------------------------------------------------------
package itp_pkg;

  localparam int TILE_W = 128;
  localparam int TILE_H = 64;
  localparam int COLS   = 16;
  localparam int ROWS   = 32;
  localparam int NTILES = ROWS * COLS;

  localparam int IDX_W = (NTILES > 1) ? $clog2(NTILES) : 1;
  localparam int COL_W = (COLS > 1) ? $clog2(COLS) : 1;

  // Bound on |a| + |b| of the edge terms over the whole grid and input range.
  localparam int ACC_MAG = (TILE_W + TILE_H) * 65536 + TILE_W * TILE_H * (2 * COLS + ROWS + 1);
  localparam int ACC_W   = $clog2(ACC_MAG) + 2;

  localparam logic signed [ACC_W-1:0] WH_C  = ACC_W'(TILE_W * TILE_H);
  localparam logic signed [ACC_W-1:0] WH2_C = ACC_W'(2 * TILE_W * TILE_H);
  localparam logic signed [ACC_W-1:0] KX_C  = ACC_W'(2 * TILE_H);
  localparam logic signed [ACC_W-1:0] KY_C  = ACC_W'(2 * TILE_W);

  localparam logic [7:0] DRAW_RST = 8'd2;
  localparam logic [7:0] OPT_RST  = 8'd0;

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_SCAN,
    ST_DONE
  } itp_state_e;

  typedef struct packed {
    logic             we;
    logic [IDX_W-1:0] addr;
    logic [7:0]       draw;
    logic [7:0]       opt;
  } itp_store_req_t;

endpackage

/* rtl/isometric_tile_pick_and_update.sv */
// ----------------------------------------------------------------------------
// isometric_tile_pick_and_update: pick a tile of a staggered isometric grid
// Searches the tiles in index order for the first diamond holding the point
// and rewrites that tile's draw id and option.
// ----------------------------------------------------------------------------
// A word is taken when start_i is high and busy_o is low. The block then
// tests one tile per cycle with a single shared edge unit, stepping the edge
// terms by constant adds, and stops at the first tile that holds the point.
// The result appears on the output ports for one cycle with done_o high and
// must be taken then, as the block cannot hold it. A scan that misses goes
// through all ROWS*COLS tiles. A new word may be started in the cycle that
// done_o is high. After reset the tile tables are cleared by a pass over all
// ROWS*COLS tiles, during which busy_o stays high.
module isometric_tile_pick_and_update (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  output logic              busy_o,
  input  logic signed [15:0] pos_x_i,
  input  logic signed [15:0] pos_y_i,
  input  logic [7:0]        new_draw_id_i,
  input  logic [7:0]        new_option_i,
  output logic              done_o,
  output logic              hit_o,
  output logic [8:0]        tile_index_o,
  output logic [7:0]        old_draw_id_o,
  output logic [7:0]        old_option_o
);
  import itp_pkg::*;

  localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(NTILES - 1);
  localparam logic [COL_W-1:0] COL_LAST = COL_W'(COLS - 1);

  itp_state_e       state_q, state_d;
  logic [IDX_W-1:0] idx_q, idx_d;
  logic [COL_W-1:0] col_q, col_d;
  logic             odd_q, odd_d;
  logic             hit_q, hit_d;

  logic signed [ACC_W-1:0] a0_q, a0_d;
  logic signed [ACC_W-1:0] a_q, a_d;
  logic signed [ACC_W-1:0] b_q, b_d;
  logic [7:0]              nd_q, nd_d;
  logic [7:0]              no_q, no_d;

  logic signed [ACC_W-1:0] px_ext;
  logic signed [ACC_W-1:0] py_ext;
  logic                    in_tile;
  logic                    accept;
  itp_store_req_t          st_req;
  logic [7:0]              rd_draw;
  logic [7:0]              rd_opt;
  logic [IDX_W+8:0]        idx_wide;

  assign px_ext = {{(ACC_W-16){pos_x_i[15]}}, pos_x_i};
  assign py_ext = {{(ACC_W-16){pos_y_i[15]}}, pos_y_i};

  itp_edge_unit u_edge (
    .a_i      (a_q),
    .b_i      (b_q),
    .inside_o (in_tile)
  );

  itp_tile_store u_store (
    .clk_i     (clk_i),
    .req_i     (st_req),
    .rd_draw_o (rd_draw),
    .rd_opt_o  (rd_opt)
  );

  assign busy_o = (state_q == ST_CLEAR) || (state_q == ST_SCAN);
  assign accept = start_i && !busy_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_CLEAR;
      idx_q   <= '0;
      col_q   <= '0;
      odd_q   <= 1'b0;
      hit_q   <= 1'b0;
    end else begin
      state_q <= state_d;
      idx_q   <= idx_d;
      col_q   <= col_d;
      odd_q   <= odd_d;
      hit_q   <= hit_d;
    end
  end

  always_ff @(posedge clk_i) begin
    a0_q <= a0_d;
    a_q  <= a_d;
    b_q  <= b_d;
    nd_q <= nd_d;
    no_q <= no_d;
  end

  always_comb begin
    state_d = state_q;
    idx_d   = idx_q;
    col_d   = col_q;
    odd_d   = odd_q;
    hit_d   = hit_q;
    a0_d    = a0_q;
    a_d     = a_q;
    b_d     = b_q;
    nd_d    = nd_q;
    no_d    = no_q;
    st_req  = '{we: 1'b0, addr: idx_q, draw: nd_q, opt: no_q};

    unique case (state_q)
      ST_CLEAR: begin
        st_req = '{we: 1'b1, addr: idx_q, draw: DRAW_RST, opt: OPT_RST};
        idx_d  = idx_q + 1'b1;
        if (idx_q == IDX_LAST) begin
          idx_d   = '0;
          state_d = ST_IDLE;
        end
      end
      ST_SCAN: begin
        if (in_tile) begin
          // Read and write on the same edge: the read register keeps the old entry.
          st_req.we = 1'b1;
          hit_d     = 1'b1;
          state_d   = ST_DONE;
        end else if (idx_q == IDX_LAST) begin
          hit_d   = 1'b0;
          state_d = ST_DONE;
        end else begin
          idx_d = idx_q + 1'b1;
          if (col_q == COL_LAST) begin
            // Next row: odd rows are shifted right by half a tile.
            col_d = '0;
            odd_d = !odd_q;
            a_d   = odd_q ? a0_q : a0_q - WH_C;
            b_d   = b_q - WH_C;
          end else begin
            col_d = col_q + 1'b1;
            a_d   = a_q - WH2_C;
          end
        end
      end
      ST_IDLE: begin
      end
      ST_DONE: begin
        state_d = ST_IDLE;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase

    if (accept) begin
      a0_d    = px_ext * KX_C;
      a_d     = px_ext * KX_C;
      b_d     = py_ext * KY_C;
      nd_d    = new_draw_id_i;
      no_d    = new_option_i;
      idx_d   = '0;
      col_d   = '0;
      odd_d   = 1'b0;
      state_d = ST_SCAN;
    end
  end

  assign idx_wide      = {9'b0, idx_q};
  assign done_o        = (state_q == ST_DONE);
  assign hit_o         = hit_q;
  assign tile_index_o  = hit_q ? idx_wide[8:0] : 9'd0;
  assign old_draw_id_o = hit_q ? rd_draw : 8'd0;
  assign old_option_o  = hit_q ? rd_opt : 8'd0;

`ifndef SYNTHESIS
  a_done_single : assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |=> !done_o)
    else $error("result strobe held for more than one cycle");

  a_hit_reports : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_SCAN && in_tile) |=> (done_o && hit_o && $stable(idx_q)))
    else $error("a found tile was not reported in the next cycle");

  a_start_scan : assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> (state_q == ST_SCAN && idx_q == '0 && !done_o))
    else $error("accepted word did not start a scan from tile zero");

  a_write_only_hit : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (st_req.we && state_q != ST_CLEAR) |-> (state_q == ST_SCAN && in_tile))
    else $error("tile table written without a hit");
`endif

endmodule

/* rtl/itp_edge_unit.sv */
// ----------------------------------------------------------------------------
// itp_edge_unit: diamond containment test
// Takes the scaled horizontal term a = 2H*ex and vertical term b = 2W*ey of
// one tile and reports whether the point lies strictly inside its diamond.
// ----------------------------------------------------------------------------
module itp_edge_unit (
  input  logic signed [itp_pkg::ACC_W-1:0] a_i,
  input  logic signed [itp_pkg::ACC_W-1:0] b_i,
  output logic                             inside_o
);
  import itp_pkg::*;

  logic signed [ACC_W-1:0] diff;
  logic signed [ACC_W-1:0] sum;

  // The diamond's edge lines reduce to |a - b| < W*H and |a + b| < W*H.
  assign diff = a_i - b_i;
  assign sum  = a_i + b_i;

  assign inside_o = (diff < WH_C) && (diff > -WH_C) && (sum < WH_C) && (sum > -WH_C);

endmodule

/* rtl/itp_tile_store.sv */
// ----------------------------------------------------------------------------
// itp_tile_store: draw id and option tables
// One port; a write returns the entry's previous contents in the read
// register on the following cycle.
// ----------------------------------------------------------------------------
module itp_tile_store (
  input  logic                    clk_i,
  input  itp_pkg::itp_store_req_t req_i,
  output logic [7:0]              rd_draw_o,
  output logic [7:0]              rd_opt_o
);
  import itp_pkg::*;

  logic [7:0] draw_mem [NTILES];
  logic [7:0] opt_mem  [NTILES];
  logic [7:0] rd_draw_q;
  logic [7:0] rd_opt_q;

  always_ff @(posedge clk_i) begin
    rd_draw_q <= draw_mem[req_i.addr];
    rd_opt_q  <= opt_mem[req_i.addr];
    if (req_i.we) begin
      draw_mem[req_i.addr] <= req_i.draw;
      opt_mem[req_i.addr]  <= req_i.opt;
    end
  end

  assign rd_draw_o = rd_draw_q;
  assign rd_opt_o  = rd_opt_q;

endmodule
